### rtl/core/mo_pkg.sv
// Shared constants, types and tables for the mecanum odometry integrator.
`timescale 1ns / 1ps
package mo_pkg;

  localparam int MUL_A_W = 35;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);
  localparam int CORDIC_ITERATIONS = 24;
  localparam int ATAN_ENTRIES = 30;
  localparam int CORDIC_STEPS =
    (CORDIC_ITERATIONS < ATAN_ENTRIES) ? CORDIC_ITERATIONS : ATAN_ENTRIES;
  localparam int ITER_W = $clog2(ATAN_ENTRIES);
  localparam int XY_W = 44;
  localparam int Z_W = 34;
  localparam logic [31:0] CORDIC_GAIN_Q32 = 32'd2608131496;

  localparam logic CFG_METERS_PER_PULSE = 1'b0;
  localparam logic CFG_TURN_PER_METER = 1'b1;

  typedef struct packed {
    logic                       start;
    logic signed [MUL_A_W-1:0]  a;
    logic [MUL_B_W-1:0]         b;
  } mul_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [MUL_P_W-1:0]  p;
  } mul_rsp_t;

  function automatic logic [31:0] atan_at(input logic [ITER_W-1:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/mo_mul.sv
// Bit-serial signed by unsigned shift-add multiplier.
`timescale 1ns / 1ps
module mo_mul (
  input  logic             clk,
  input  logic             rst,
  input  mo_pkg::mul_req_t req,
  output mo_pkg::mul_rsp_t rsp
);
  import mo_pkg::*;

  logic signed [MUL_P_W-1:0] acc;
  logic signed [MUL_P_W-1:0] mcand;
  logic [MUL_B_W-1:0]        mplier;
  logic [MUL_CNT_W-1:0]      cnt;
  logic                      busy;
  logic                      done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        acc    <= '0;
        mcand  <= MUL_P_W'(req.a);
        mplier <= req.b;
      end else if (busy) begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.p    = acc;

endmodule

### rtl/core/mecanum_odometry_integrator.sv
// Top level: mecanum wheel odometry with serial multiplier and CORDIC rotation.
// Flow from accept to m_tvalid: four wheel multiplies, a body step, three more serial
// multiplies (vx gain, vy gain, turn), an angle step, the CORDIC iterations and an output step.
// A new request is taken only in S_IDLE, after the last one leaves S_OUT; one shared multiplier.
// A finished result waits in the output register while the next request is taken.
// Reset (rst, synchronous) clears counts, pose, heading and both registers.
`timescale 1ns / 1ps
module mecanum_odometry_integrator (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // count_front_left, count_wheel_one, count_wheel_two, count_wheel_three
  input  logic [127:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // pos_x, pos_y, heading
  output logic [95:0]  m_tdata
);
  import mo_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_WAIT, S_BODY, S_PREP, S_CORDIC, S_OUT
  } state_t;

  state_t state;
  logic [31:0] meters_per_pulse, turn_per_meter;
  logic [31:0] prev [4];
  logic [31:0] diff [4];
  logic signed [31:0] d [4];
  logic signed [33:0] vx, vy;
  logic signed [34:0] vw;
  logic signed [XY_W-1:0] cx, cy;
  logic signed [Z_W-1:0] cz;
  logic [31:0] turn;
  logic [2:0] op;
  logic [ITER_W-1:0] iter;
  logic [31:0] acc_x, acc_y, acc_heading;
  logic out_valid;

  mul_req_t mreq;
  mul_rsp_t mrsp;

  mo_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));

  always_comb begin
    mreq.start = (state == S_START);
    unique case (op)
      3'd0: begin mreq.a = 35'(signed'(diff[0])); mreq.b = meters_per_pulse; end
      3'd1: begin mreq.a = 35'(signed'(diff[1])); mreq.b = meters_per_pulse; end
      3'd2: begin mreq.a = 35'(signed'(diff[2])); mreq.b = meters_per_pulse; end
      3'd3: begin mreq.a = 35'(signed'(diff[3])); mreq.b = meters_per_pulse; end
      3'd4: begin mreq.a = 35'(vx); mreq.b = CORDIC_GAIN_Q32; end
      3'd5: begin mreq.a = 35'(vy); mreq.b = CORDIC_GAIN_Q32; end
      default: begin mreq.a = vw; mreq.b = turn_per_meter; end
    endcase
  end

  logic signed [MUL_P_W-9:0] p_sh8;
  logic signed [31:0] d_sat;
  always_comb begin
    p_sh8 = mrsp.p[MUL_P_W-1:8];
    if (p_sh8 > 59'sd2147483647) d_sat = 32'sh7fffffff;
    else if (p_sh8 < -59'sd2147483648) d_sat = 32'sh80000000;
    else d_sat = p_sh8[31:0];
  end

  logic signed [33:0] s03, s12;
  logic signed [34:0] wsum;
  always_comb begin
    s03 = 34'(d[0]) + 34'(d[3]);
    s12 = 34'(d[1]) + 34'(d[2]);
    wsum = -35'(d[0]) + 35'(d[1]) - 35'(d[2]) + 35'(d[3]);
  end

  logic signed [Z_W-1:0] z0;
  logic big;
  always_comb begin
    z0 = Z_W'(signed'(acc_heading + 32'h20000000));
    big = (z0 > 34'sd1073741824) || (z0 < -34'sd1073741824);
  end

  logic signed [XY_W-1:0] xs, ys;
  logic signed [Z_W-1:0] at;
  always_comb begin
    xs = cx >>> iter;
    ys = cy >>> iter;
    at = Z_W'(atan_at(iter));
  end

  logic signed [XY_W-9:0] fx, fy;
  function automatic logic [31:0] sadd(input logic [31:0] a,
                                       input logic signed [XY_W-9:0] v);
    logic signed [31:0] sv;
    logic signed [32:0] s;
    if (v > 36'sd2147483647) sv = 32'sh7fffffff;
    else if (v < -36'sd2147483648) sv = 32'sh80000000;
    else sv = v[31:0];
    s = 33'(signed'(a)) + 33'(sv);
    if (s > 33'sd2147483647) return 32'h7fffffff;
    else if (s < -33'sd2147483648) return 32'h80000000;
    else return s[31:0];
  endfunction
  always_comb begin
    fx = cx[XY_W-1:8];
    fy = cy[XY_W-1:8];
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {acc_heading, acc_y, acc_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      meters_per_pulse <= '0;
      turn_per_meter <= '0;
      for (int i = 0; i < 4; i++) prev[i] <= '0;
      acc_x <= '0;
      acc_y <= '0;
      acc_heading <= '0;
      out_valid <= 1'b0;
      op <= '0;
      iter <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_METERS_PER_PULSE: meters_per_pulse <= cfg_data;
          CFG_TURN_PER_METER:   turn_per_meter <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && m_tready && state != S_OUT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            for (int i = 0; i < 4; i++) begin
              diff[i] <= s_tdata[32*i +: 32] - prev[i];
              prev[i] <= s_tdata[32*i +: 32];
            end
            op <= '0;
            state <= S_START;
          end
        end
        S_START: state <= S_WAIT;
        S_WAIT: begin
          if (mrsp.done) begin
            op <= op + 1'b1;
            priority case (1'b1)
              (op < 3'd4): d[op[1:0]] <= d_sat;
              (op == 3'd4): cx <= XY_W'(mrsp.p >>> 24);
              (op == 3'd5): cy <= XY_W'(mrsp.p >>> 24);
              default: turn <= mrsp.p[39:8];
            endcase
            priority if (op == 3'd3) state <= S_BODY;
            else if (op == 3'd6) state <= S_PREP;
            else state <= S_START;
          end
        end
        S_BODY: begin
          vx <= s03 >>> 1;
          vy <= s12 >>> 1;
          vw <= wsum >>> 2;
          state <= S_START;
        end
        S_PREP: begin
          if (big) begin
            cx <= -cx;
            cy <= -cy;
            cz <= (z0 > 0) ? z0 - 34'sd2147483648 : z0 + 34'sd2147483648;
          end else begin
            cz <= z0;
          end
          iter <= '0;
          state <= S_CORDIC;
        end
        S_CORDIC: begin
          if (!cz[Z_W-1]) begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - at;
          end else begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + at;
          end
          iter <= iter + 1'b1;
          if (iter == ITER_W'(CORDIC_STEPS - 1)) state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || m_tready) begin
            acc_x <= sadd(acc_x, fx);
            acc_y <= sadd(acc_y, fy);
            acc_heading <= acc_heading + turn;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### bench/testbench.sv
// Self-checking bench for the mecanum odometry integrator: directed table then random counts.
`timescale 1ns / 1ps
module testbench;
  import mo_pkg::*;

  typedef struct {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] hd;
  } pose_t;

  typedef struct {
    logic [127:0] counts;
    bit           typed;
    pose_t        pose;
  } row_t;

  localparam int DRAIN_CYCLES = 400;
  localparam int HOLD_CYCLES = 3000;
  localparam int RANDOM_ITEMS = 620;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic         cfg_index = CFG_METERS_PER_PULSE;
  logic [31:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [95:0]  m_tdata;

  logic [31:0] last_counts [4];
  logic [31:0] mpp_reg, tpm_reg;
  logic [31:0] acc_x, acc_y, acc_hd;
  longint      atan_q [30];

  pose_t pose_q [$];
  row_t  lit_q [$];
  row_t  table_rows [$];
  int    mismatches = 0;
  bit    calm = 1'b0;
  int    hold_left = 0;
  logic [31:0] drive_counts [4];

  mecanum_odometry_integrator u_dut (.*);

  always #5 clk = ~clk;

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] acc, input longint delta);
    longint s;
    s = clamp32(longint'($signed(acc)) + clamp32(delta));
    return s[31:0];
  endfunction

  function automatic pose_t integrate_counts(input logic [127:0] word);
    longint d [4];
    longint vx, vy, vw, x, y, z, nx, ny, turn;
    logic [31:0] dl, theta;
    pose_t r;
    for (int i = 0; i < 4; i++) begin
      dl = word[32*i +: 32] - last_counts[i];
      d[i] = clamp32((longint'($signed(dl)) * longint'({32'd0, mpp_reg})) >>> 8);
      last_counts[i] = word[32*i +: 32];
    end
    vx = (d[0] + d[3]) >>> 1;
    vy = (d[1] + d[2]) >>> 1;
    vw = (-d[0] + d[1] - d[2] + d[3]) >>> 2;
    theta = acc_hd + 32'h2000_0000;
    z = longint'($signed(theta));
    x = (vx * longint'({32'd0, CORDIC_GAIN_Q32})) >>> 24;
    y = (vy * longint'({32'd0, CORDIC_GAIN_Q32})) >>> 24;
    if (z > 64'sd1073741824 || z < -64'sd1073741824) begin
      x = -x;
      y = -y;
      z = (z > 0) ? z - 64'sd2147483648 : z + 64'sd2147483648;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= atan_q[i];
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += atan_q[i];
      end
      x = nx;
      y = ny;
    end
    acc_x = sat_add(acc_x, x >>> 8);
    acc_y = sat_add(acc_y, y >>> 8);
    turn = (vw * longint'({32'd0, tpm_reg})) >>> 8;
    acc_hd = acc_hd + turn[31:0];
    r.px = acc_x;
    r.py = acc_y;
    r.hd = acc_hd;
    return r;
  endfunction

  // model tracks writes and accepted requests at the same edge the block sees them
  always @(posedge clk) begin
    if (rst) begin
      foreach (last_counts[i]) last_counts[i] = '0;
      acc_x = '0;
      acc_y = '0;
      acc_hd = '0;
      mpp_reg = '0;
      tpm_reg = '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_METERS_PER_PULSE) mpp_reg = cfg_data;
        else tpm_reg = cfg_data;
      end
      if (s_tvalid && s_tready) pose_q.push_back(integrate_counts(s_tdata));
    end
  end

  always @(posedge clk) begin
    pose_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got.px = m_tdata[31:0];
      got.py = m_tdata[63:32];
      got.hd = m_tdata[95:64];
      if (pose_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_tdata);
      end else begin
        want = pose_q.pop_front();
        if (lit_q.size() > 0 && lit_q[0].typed) want = lit_q[0].pose;
        if (lit_q.size() > 0) void'(lit_q.pop_front());
        if (got.px !== want.px || got.py !== want.py || got.hd !== want.hd) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%h y=%h hd=%h, got x=%h y=%h hd=%h",
                     want.px, want.py, want.hd, got.px, got.py, got.hd);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= rst ? 1'b0 : (calm || $urandom_range(99) >= 10);
    end
  end

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic settle();
    wait (pose_q.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_counts(input logic [127:0] word, input bit typed, input pose_t p);
    row_t r;
    while (!calm && $urandom_range(99) < 10) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    r.counts = word;
    r.typed = typed;
    r.pose = p;
    lit_q.push_back(r);
    s_tvalid = 1'b1;
    s_tdata = word;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    s_tvalid = 1'b0;
    for (int i = 0; i < 4; i++) drive_counts[i] = word[32*i +: 32];
  endtask

  task automatic add_row(input logic [31:0] c0, c1, c2, c3, input bit typed);
    row_t r;
    r.counts = {c3, c2, c1, c0};
    r.typed = typed;
    r.pose = '{32'd0, 32'd0, 32'd0};
    table_rows.push_back(r);
  endtask

  function automatic logic [127:0] next_counts();
    logic [127:0] w;
    int span;
    if ($urandom_range(99) < 15) return {$urandom, $urandom, $urandom, $urandom};
    span = ($urandom_range(9) == 0) ? 100000 : 300;
    for (int i = 0; i < 4; i++)
      w[32*i +: 32] = drive_counts[i] + $urandom_range(2 * span) - span;
    return w;
  endfunction

  initial begin
    logic [31:0] mpp_set [6];
    logic [31:0] tpm_set [6];
    pose_t zero_pose;
    atan_q = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
               10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
               41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
               10, 5, 3, 1};
    mpp_set = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_4000, 32'h0001_0000,
                32'h0100_0000, 32'h0000_0100};
    tpm_set = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0100_0000, 32'h0040_0000,
                32'h0800_0000, 32'h0000_1000};
    zero_pose = '{32'd0, 32'd0, 32'd0};
    foreach (drive_counts[i]) drive_counts[i] = '0;

    // with both registers at zero every pose stays at the origin
    add_row(32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
    add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    add_row(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    add_row(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);

    repeat (12) @(negedge clk);
    rst = 1'b0;
    foreach (table_rows[i]) send_counts(table_rows[i].counts, 1'b1, zero_pose);
    settle();

    // extreme gains: saturating wheel distance, saturating position, wrapping heading
    table_rows.delete();
    write_reg(CFG_METERS_PER_PULSE, 32'hFFFF_FFFF);
    write_reg(CFG_TURN_PER_METER, 32'hFFFF_FFFF);
    add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    add_row(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    add_row(32'h0000_0010, 32'hFFFF_FFF0, 32'h0000_0010, 32'hFFFF_FFF0, 1'b0);
    add_row(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    foreach (table_rows[i]) send_counts(table_rows[i].counts, 1'b0, zero_pose);
    settle();

    // moderate gains: steady count steps move the position; the heading turns on the first row only
    table_rows.delete();
    write_reg(CFG_METERS_PER_PULSE, 32'h0100_0000);
    write_reg(CFG_TURN_PER_METER, 32'h0040_0000);
    for (int k = 1; k <= 12; k++)
      add_row(-k * 37, k * 53, -k * 41, k * 29 + 700, 1'b0);
    foreach (table_rows[i]) send_counts(table_rows[i].counts, 1'b0, zero_pose);
    settle();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        settle();
        write_reg(CFG_METERS_PER_PULSE, mpp_set[(n / 100) % 6]);
        write_reg(CFG_TURN_PER_METER, tpm_set[(n / 100) % 6]);
      end
      if (n == 150) calm = 1'b1;
      if (n == 230) calm = 1'b0;
      if (n == 300) hold_left = HOLD_CYCLES;
      if (n == 450) wait (pose_q.size() == 0);
      send_counts(next_counts(), 1'b0, zero_pose);
    end

    wait (pose_q.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### sim.f
rtl/core/mo_pkg.sv
rtl/core/mo_mul.sv
rtl/core/mecanum_odometry_integrator.sv
bench/testbench.sv
